FILE: hw/rtl/linear_probe_hash_table_assert.svh
// Assertion macros for the linear probe hash table.
// They use the clk and rst_n names of the module that includes them.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// The condition c holds in the same cycle as a.
`define LPHT_ASSERT_SAME(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// The condition c holds in the cycle after a.
`define LPHT_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

FILE: hw/rtl/lpht_pkg.sv
// Shared types, constants and helpers for the linear probe hash table.
// No dependencies; every RTL module refers to it by scoped names.
`default_nettype none

package lpht_pkg;

  localparam int MAX_SLOTS     = 16;
  localparam int KEY_BITS      = 15;
  localparam int SLOT_BITS     = $clog2(MAX_SLOTS);
  localparam int LIVE_BITS     = SLOT_BITS + 1;
  localparam int KCNT_BITS     = $clog2(KEY_BITS);
  localparam int CFG_SIZE_BITS = 5;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_SIZE_BITS-1:0] TABLE_SIZE_RESET = CFG_SIZE_BITS'(12);
  localparam logic                     REG_TABLE_SIZE   = 1'b0;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_FOUND    = 2'd2,
    STAT_MISSING  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_PROBE
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [KEY_BITS-1:0]  key;
    logic [LIVE_BITS-1:0] size;
  } mod_req_t;

  typedef struct packed {
    logic                 done;
    logic [SLOT_BITS-1:0] rem;
  } mod_rsp_t;

  // Number of slots that take part in probing: zero acts as one, and the
  // value saturates at the number of physical slots.
  function automatic logic [LIVE_BITS-1:0] live_size(input logic [CFG_SIZE_BITS-1:0] size);
    int s;
    s = int'(size);
    if (s == 0) begin
      s = 1;
    end else if (s > MAX_SLOTS) begin
      s = MAX_SLOTS;
    end
    return LIVE_BITS'(s);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/linear_probe_hash_table.sv
// Top level of the linear probe hash table: APB register, command FSM, probing.
// Depends on lpht_pkg, lpht_mod, lpht_table and linear_probe_hash_table_assert.svh.
//
//   Channel   Handshake                       Payload
//   ------    ------------------------------  ------------------------------
//   input     start & !busy                   in_mode, in_key
//   result    out_valid (one-cycle strobe)    out_status, out_slot_address
//   config    psel & penable & pwrite         paddr, pwdata (prdata on read)
//
// An item first gets its remainder in lpht_mod (one key bit a cycle, then
// done), then probes one slot a cycle, 1 to live_size(table_size) slots, and
// ends with the registered result beat.
// busy stays high until the result beat is produced.
// rst_n is synchronous; it empties every slot and sets table_size to 12.
// The result beat cannot be stalled; a new start is taken in its cycle.
`default_nettype none

module linear_probe_hash_table (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Input channel
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_mode,
  input  wire logic [lpht_pkg::KEY_BITS-1:0]      in_key,
  // Result channel
  output logic                                    out_valid,
  output logic [1:0]                              out_status,
  output logic [lpht_pkg::SLOT_BITS-1:0]          out_slot_address,
  // Configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [lpht_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [lpht_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [lpht_pkg::CFG_DATA_BITS-1:0]      prdata,
  output logic                                    pready
);

  lpht_pkg::state_t state_r, state_nxt;

  logic [lpht_pkg::CFG_SIZE_BITS-1:0] table_size_r;

  logic                           mode_r;
  logic [lpht_pkg::KEY_BITS-1:0]  key_r;
  logic [lpht_pkg::LIVE_BITS-1:0] live_r;
  logic [lpht_pkg::SLOT_BITS-1:0] slot_r;
  logic [lpht_pkg::SLOT_BITS-1:0] cnt_r;

  logic                           out_valid_r;
  lpht_pkg::status_t              out_status_r;
  logic [lpht_pkg::SLOT_BITS-1:0] out_slot_r;

  lpht_pkg::mod_req_t mod_req;
  lpht_pkg::mod_rsp_t mod_rsp;

  logic                           rd_valid;
  logic [lpht_pkg::KEY_BITS-1:0]  rd_key;
  logic                           wr_en;
  logic                           accept;
  logic                           last_probe;
  logic                           finish;
  lpht_pkg::status_t              res_status;
  logic [lpht_pkg::SLOT_BITS-1:0] res_slot;
  logic [lpht_pkg::SLOT_BITS-1:0] slot_inc;
  logic                           cfg_wr;

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == lpht_pkg::REG_TABLE_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= lpht_pkg::TABLE_SIZE_RESET;
    end else if (cfg_wr) begin
      table_size_r <= pwdata[lpht_pkg::CFG_SIZE_BITS-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == lpht_pkg::REG_TABLE_SIZE) begin
      prdata = lpht_pkg::CFG_DATA_BITS'(table_size_r);
    end else begin
      prdata = '0;
    end
  end

  // ---------------------------------------------------------------------
  // Sub-units
  // ---------------------------------------------------------------------
  lpht_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  lpht_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_slot  (slot_r),
    .wr_key   (key_r),
    .rd_slot  (slot_r),
    .rd_valid (rd_valid),
    .rd_key   (rd_key)
  );

  // ---------------------------------------------------------------------
  // Probe datapath
  // ---------------------------------------------------------------------
  assign busy       = (state_r != lpht_pkg::S_IDLE);
  assign accept     = start && !busy;
  assign last_probe = ({1'b0, cnt_r} == (live_r - lpht_pkg::LIVE_BITS'(1)));

  always_comb begin
    if (({1'b0, slot_r} + lpht_pkg::LIVE_BITS'(1)) == live_r) begin
      slot_inc = '0;
    end else begin
      slot_inc = slot_r + 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpht_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = lpht_pkg::S_HASH;
        end
      end
      lpht_pkg::S_HASH: begin
        if (mod_rsp.done) begin
          state_nxt = lpht_pkg::S_PROBE;
        end
      end
      lpht_pkg::S_PROBE: begin
        if (finish) begin
          state_nxt = lpht_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lpht_pkg::S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------
  always_comb begin
    mod_req.start = 1'b0;
    mod_req.key   = in_key;
    mod_req.size  = lpht_pkg::live_size(table_size_r);
    wr_en         = 1'b0;
    finish        = 1'b0;
    res_status    = lpht_pkg::STAT_MISSING;
    res_slot      = '0;
    case (state_r)
      lpht_pkg::S_IDLE: begin
        mod_req.start = accept;
      end
      lpht_pkg::S_HASH: begin
        mod_req.start = 1'b0;
      end
      lpht_pkg::S_PROBE: begin
        if (mode_r == lpht_pkg::MODE_INSERT) begin
          if (!rd_valid) begin
            wr_en      = 1'b1;
            finish     = 1'b1;
            res_status = lpht_pkg::STAT_INSERTED;
            res_slot   = slot_r;
          end else if (last_probe) begin
            finish     = 1'b1;
            res_status = lpht_pkg::STAT_FULL;
          end
        end else begin
          // A search stops at an empty slot, a match, or after one full lap.
          if (rd_valid && (rd_key == key_r)) begin
            finish     = 1'b1;
            res_status = lpht_pkg::STAT_FOUND;
            res_slot   = slot_r;
          end else if (!rd_valid || last_probe) begin
            finish     = 1'b1;
            res_status = lpht_pkg::STAT_MISSING;
          end
        end
      end
      default: begin
        finish = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpht_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      key_r  <= in_key;
      live_r <= mod_req.size;
    end
    if ((state_r == lpht_pkg::S_HASH) && mod_rsp.done) begin
      slot_r <= mod_rsp.rem;
      cnt_r  <= '0;
    end else if (state_r == lpht_pkg::S_PROBE) begin
      slot_r <= slot_inc;
      cnt_r  <= cnt_r + 1'b1;
    end
    if (finish) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot_address = out_slot_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
`include "linear_probe_hash_table_assert.svh"

  `LPHT_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted item did not raise busy")
  `LPHT_ASSERT_NEXT(a_one_beat, out_valid, !out_valid, "result beat lasted over one cycle")
  `LPHT_ASSERT_SAME(a_beat_from_probe, out_valid, $past(state_r == lpht_pkg::S_PROBE), "result beat without a probe")
  `LPHT_ASSERT_SAME(a_mod_in_hash, mod_rsp.done, state_r == lpht_pkg::S_HASH, "remainder finished outside the hash phase")

endmodule

`default_nettype wire

FILE: hw/rtl/lpht_mod.sv
// Iterative remainder unit: key mod size, one key bit per cycle.
// Depends on lpht_pkg for widths and the request and response structs.
`default_nettype none

module lpht_mod (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lpht_pkg::mod_req_t req,
  output lpht_pkg::mod_rsp_t     rsp
);

  logic                           busy_r;
  logic                           done_r;
  logic [lpht_pkg::KCNT_BITS-1:0] cnt_r;
  logic [lpht_pkg::KEY_BITS-1:0]  sh_r;
  logic [lpht_pkg::SLOT_BITS-1:0] rem_r;
  logic [lpht_pkg::LIVE_BITS-1:0] div_r;

  logic [lpht_pkg::LIVE_BITS-1:0] trial;
  logic [lpht_pkg::SLOT_BITS-1:0] rem_nxt;

  // Restoring step: the partial remainder stays below the divisor, so
  // doubling it and adding one key bit fits one bit more than a slot index.
  assign trial = {rem_r, sh_r[lpht_pkg::KEY_BITS-1]};

  always_comb begin
    if (trial >= div_r) begin
      rem_nxt = lpht_pkg::SLOT_BITS'(trial - div_r);
    end else begin
      rem_nxt = lpht_pkg::SLOT_BITS'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sh_r  <= req.key;
      div_r <= req.size;
      rem_r <= '0;
      cnt_r <= lpht_pkg::KCNT_BITS'(lpht_pkg::KEY_BITS - 1);
    end else if (busy_r) begin
      sh_r  <= {sh_r[lpht_pkg::KEY_BITS-2:0], 1'b0};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

FILE: hw/rtl/lpht_table.sv
// Slot storage: stored keys and the valid bits that mark occupied slots.
// Depends on lpht_pkg for the slot count and key width.
`default_nettype none

module lpht_table (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [lpht_pkg::SLOT_BITS-1:0] wr_slot,
  input  wire logic [lpht_pkg::KEY_BITS-1:0]  wr_key,
  input  wire logic [lpht_pkg::SLOT_BITS-1:0] rd_slot,
  output logic                                rd_valid,
  output logic [lpht_pkg::KEY_BITS-1:0]       rd_key
);

  logic [lpht_pkg::MAX_SLOTS-1:0] valid_r;
  logic [lpht_pkg::KEY_BITS-1:0]  keys_r [lpht_pkg::MAX_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_slot] <= 1'b1;
    end
  end

  // Key words carry no reset; a slot is only compared once its valid bit is set.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys_r[wr_slot] <= wr_key;
    end
  end

  assign rd_valid = valid_r[rd_slot];
  assign rd_key   = keys_r[rd_slot];

endmodule

`default_nettype wire
